// File: hw/rtl/clm_pkg.sv
// clm_pkg: shared constants and types for the CPU load level meter.
// No dependencies.
package clm_pkg;
  localparam int TickW      = 48;
  localparam int SumW       = 50;
  localparam int LevelW     = 9;
  localparam int DefWindow  = 16;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 8;
  localparam logic [CfgIdxW-1:0] RegExcludeNice = 2'd0;
  localparam logic [CfgIdxW-1:0] RegThreshold   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIncremental = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFrameCount  = 2'd3;

  typedef struct packed {
    logic [SumW-1:0] busy;
    logic [SumW-1:0] total;
  } sample_t;

  typedef struct packed {
    logic            zero;   // load forced to 0
    logic            sat;    // load forced to 256
    logic [SumW-1:0] dbusy;
    logic [SumW-1:0] dtotal;
  } job_t;
endpackage

// File: hw/rtl/cpu_load_level_meter.sv
// cpu_load_level_meter: top level, config registers, front, queue, back.
// Depends on clm_pkg, clm_front, clm_queue, clm_back.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | four 48-bit tick counters
//  out_    | output    | out_valid / out_ready| level, changed, frame fields
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// An item passes the front's accept, classify and hand-off states, the
// queue, and the back: the one-bit-per-cycle divider shared by the load,
// remap, range and frame divisions runs 58 + 17 + 9 + 9 steps plus one
// collect step each, with five control states around them.
// A forced load skips the first division, a disabled or missed threshold
// the second. Reset is synchronous, active low; the sample ring needs no
// clearing pass since per-slot valid bits make unwritten slots read as zero.
// The queue lets the front take the next beat while the back still works
// or the output beat waits for out_ready.
module cpu_load_level_meter import clm_pkg::*; #(
  parameter int WindowDepth = DefWindow
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TickW-1:0]   in_user_ticks,
  input  logic [TickW-1:0]   in_nice_ticks,
  input  logic [TickW-1:0]   in_system_ticks,
  input  logic [TickW-1:0]   in_idle_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LevelW-1:0]  out_level,
  output logic               out_changed,
  output logic [5:0]         out_frame_index,
  output logic [5:0]         out_next_frame_index,
  output logic [7:0]         out_blend_weight,
  output logic [LevelW-1:0]  out_blend_range
);
  logic       excl_r, incr_r;
  logic [7:0] thr_r;
  logic [6:0] frames_r;
  logic       fj_valid, fj_ready, bj_valid, bj_ready;
  job_t       fj, bj;

  // Config writes: no index is ignored; the index fits the list exactly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excl_r <= 1'b0; thr_r <= '0; incr_r <= 1'b0; frames_r <= 7'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegExcludeNice: excl_r   <= cfg_data[0];
        RegThreshold:   thr_r    <= cfg_data;
        RegIncremental: incr_r   <= cfg_data[0];
        RegFrameCount:  frames_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  clm_front #(.WindowDepth(WindowDepth)) u_front (
    .clk, .rst_n, .exclude_nice(excl_r),
    .in_valid, .in_ready, .in_user_ticks, .in_nice_ticks,
    .in_system_ticks, .in_idle_ticks,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  clm_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
  );

  clm_back u_back (
    .clk, .rst_n, .threshold(thr_r), .incremental(incr_r),
    .frame_count(frames_r), .job_valid(bj_valid), .job_ready(bj_ready),
    .job(bj), .out_valid, .out_ready, .out_level, .out_changed,
    .out_frame_index, .out_next_frame_index, .out_blend_weight,
    .out_blend_range
  );
endmodule

// File: hw/rtl/clm_front.sv
// clm_front: sums the tick counters, reads and updates the sample ring,
// and classifies each beat into a division job. Depends on clm_pkg.
module clm_front import clm_pkg::*; #(
  parameter int WindowDepth = DefWindow
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            exclude_nice,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [TickW-1:0] in_user_ticks,
  input  logic [TickW-1:0] in_nice_ticks,
  input  logic [TickW-1:0] in_system_ticks,
  input  logic [TickW-1:0] in_idle_ticks,
  output logic            job_valid,
  input  logic            job_ready,
  output job_t            job
);
  localparam int SlotW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;

  sample_t         ring_r [WindowDepth];
  logic [WindowDepth-1:0] used_r;
  logic [SlotW-1:0] slot_r;
  logic [1:0]      st_r;          // 0 idle, 1 calc, 2 job out
  sample_t         new_r, old_r;
  logic            old_used_r;
  job_t            job_r;

  localparam logic [1:0] StIdle = 2'd0, StCalc = 2'd1, StOut = 2'd2;

  logic [SumW-1:0] busy_sum, total_sum, dbusy, dtotal;
  logic [SumW-1:0] old_busy, old_total;

  assign in_ready  = (st_r == StIdle);
  assign job_valid = (st_r == StOut);
  assign job       = job_r;

  always_comb begin
    busy_sum = SumW'(in_user_ticks) + SumW'(in_system_ticks)
               + (exclude_nice ? '0 : SumW'(in_nice_ticks));
    total_sum = SumW'(in_user_ticks) + SumW'(in_nice_ticks)
                + SumW'(in_system_ticks) + SumW'(in_idle_ticks);
    old_busy  = old_used_r ? old_r.busy : '0;
    old_total = old_used_r ? old_r.total : '0;
    dbusy  = new_r.busy - old_busy;
    dtotal = new_r.total - old_total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= StIdle;
      used_r <= '0;
      slot_r <= '0;
    end else begin
      unique case (st_r)
        StIdle: if (in_valid) begin
          new_r.busy  <= busy_sum;
          new_r.total <= total_sum;
          old_r       <= ring_r[slot_r];
          old_used_r  <= used_r[slot_r];
          ring_r[slot_r].busy  <= busy_sum;
          ring_r[slot_r].total <= total_sum;
          used_r[slot_r] <= 1'b1;
          slot_r <= (32'(slot_r) == WindowDepth - 1) ? '0 : slot_r + 1'b1;
          st_r   <= StCalc;
        end
        StCalc: begin
          job_r.zero   <= (old_total == '0) || (new_r.total == old_total);
          job_r.sat    <= (dbusy >= dtotal);
          job_r.dbusy  <= dbusy;
          job_r.dtotal <= dtotal;
          st_r <= StOut;
        end
        StOut: if (job_ready) st_r <= StIdle;
        default: st_r <= StIdle;
      endcase
    end
  end
endmodule

// File: hw/rtl/clm_queue.sv
// clm_queue: two-entry queue of division jobs between front and back.
// Depends on clm_pkg.
module clm_queue import clm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// File: hw/rtl/clm_back.sv
// clm_back: divides, remaps, integrates and splits the level into frames,
// one shared restoring divider. Depends on clm_pkg.
module clm_back import clm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        threshold,
  input  logic              incremental,
  input  logic [6:0]        frame_count,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LevelW-1:0] out_level,
  output logic              out_changed,
  output logic [5:0]        out_frame_index,
  output logic [5:0]        out_next_frame_index,
  output logic [7:0]        out_blend_weight,
  output logic [LevelW-1:0] out_blend_range
);
  localparam logic [3:0] StIdle = 4'd0, StLoad = 4'd1, StRemap = 4'd2,
    StRemapW = 4'd3, StInteg = 4'd4, StRng = 4'd5, StRngW = 4'd6,
    StIdx = 4'd7, StIdxW = 4'd8, StOut = 4'd9;
  localparam int DivW = SumW + 8;

  logic [3:0] st_r;
  // shared divider: num / den, quotient in num_r, remainder in rem_r;
  // the dividend is left-aligned in num_r, one step per dividend bit
  logic [DivW-1:0] num_r;
  logic [DivW-1:0] den_r;
  logic [DivW:0]   rem_r;
  logic [5:0]      cnt_r;
  logic [DivW:0]   trial, shifted;
  logic [8:0]      load_r, level_r, range_r, last_lvl_r, integ_r;
  logic [5:0]      last_r, idx;
  logic [6:0]      frames;
  logic signed [10:0] isum;
  logic [8:0]      q9;
  logic [13:0]     load41;

  always_comb begin
    shifted = {rem_r[DivW-1:0], num_r[DivW-1]};
    trial   = shifted - {1'b0, den_r};
    frames  = (frame_count < 7'd2) ? 7'd2 : (frame_count > 7'd64) ? 7'd64 : frame_count;
    q9      = num_r[8:0];
    // load / 50 as load * 41 >> 11, exact over 0..256
    load41  = 14'(load_r) * 14'd41;
    isum    = $signed({2'b0, integ_r}) + $signed({8'b0, load41[13:11]}) - 11'sd3;
    idx     = (q9 > {3'b0, last_r}) ? last_r : q9[5:0];
  end

  assign job_ready = (st_r == StIdle);
  assign out_valid = (st_r == StOut);
  assign out_level = level_r;
  assign out_blend_range = range_r;
  assign out_next_frame_index = (out_frame_index == last_r) ? last_r : out_frame_index + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle; integ_r <= '0; last_lvl_r <= '0;
    end else begin
      unique case (st_r)
        StIdle: if (job_valid) begin
          if (job.zero || job.sat) begin
            load_r <= job.zero ? 9'd0 : 9'd256;
            st_r <= StRemap;
          end else begin
            num_r <= {job.dbusy, 8'd0}; den_r <= DivW'(job.dtotal);
            rem_r <= '0; cnt_r <= 6'(DivW); st_r <= StLoad;
          end
        end
        StLoad, StRemapW, StRngW, StIdxW: begin
          if (cnt_r == '0) begin
            unique case (st_r)
              StLoad:   begin load_r <= q9; st_r <= StRemap; end
              StRemapW: begin load_r <= q9; st_r <= StInteg; end
              StRngW:   begin range_r <= q9; st_r <= StIdx; end
              default:  begin
                out_frame_index  <= idx;
                out_blend_weight <= rem_r[7:0];
                st_r <= StOut;
              end
            endcase
          end else begin
            if (!trial[DivW]) rem_r <= trial; else rem_r <= shifted;
            num_r <= {num_r[DivW-2:0], ~trial[DivW]};
            cnt_r <= cnt_r - 1'b1;
          end
        end
        StRemap: begin
          if (threshold == 8'd0) st_r <= StInteg;
          else if (load_r < {1'b0, threshold}) begin load_r <= '0; st_r <= StInteg; end
          else begin
            num_r <= {(load_r - {1'b0, threshold}), 8'd0, {(DivW-17){1'b0}}};
            den_r <= DivW'(9'd256 - {1'b0, threshold});
            rem_r <= '0; cnt_r <= 6'd17; st_r <= StRemapW;
          end
        end
        StInteg: begin
          integ_r <= (isum < 0) ? 9'd0 : (isum > 11'sd256) ? 9'd256 : isum[8:0];
          level_r <= incremental
            ? ((isum < 0) ? 9'd0 : (isum > 11'sd256) ? 9'd256 : isum[8:0]) : load_r;
          last_r <= 6'(frames - 7'd1);
          num_r <= {9'd256, {(DivW-9){1'b0}}}; den_r <= DivW'(frames - 7'd1);
          rem_r <= '0; cnt_r <= 6'd9; st_r <= StRngW;
        end
        StIdx: begin
          num_r <= {level_r, {(DivW-LevelW){1'b0}}}; den_r <= DivW'(range_r);
          rem_r <= '0; cnt_r <= 6'd9; st_r <= StIdxW;
        end
        StOut: if (out_ready) begin
          last_lvl_r <= level_r; st_r <= StIdle;
        end
        default: st_r <= StIdle;
      endcase
    end
  end
  assign out_changed = (level_r != last_lvl_r);
endmodule

// File: test/tb_cpu_load_level_meter.sv
// tb_cpu_load_level_meter: self-checking testbench for the CPU load level meter.
// Drives tick-counter beats, predicts every result beat, compares field by field.
// Depends on clm_pkg and cpu_load_level_meter.
`timescale 1ns / 1ps

module tb_cpu_load_level_meter;
  import clm_pkg::*;

  localparam int Depth = DefWindow;
  localparam logic [SumW-1:0] Mask50 = {SumW{1'b1}};

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              changed;
    logic [5:0]        frame;
    logic [5:0]        next_frame;
    logic [7:0]        weight;
    logic [LevelW-1:0] range;
  } meter_res_t;

  typedef struct packed {
    logic [TickW-1:0] user;
    logic [TickW-1:0] nice;
    logic [TickW-1:0] sys;
    logic [TickW-1:0] idle;
  } ticks_t;

  // One row of the directed table; chk says whether a typed-in result is compared.
  typedef struct packed {
    ticks_t     t;
    logic       chk;
    meter_res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TickW-1:0] in_user_ticks = '0, in_nice_ticks = '0;
  logic [TickW-1:0] in_system_ticks = '0, in_idle_ticks = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LevelW-1:0] out_level, out_blend_range;
  logic out_changed;
  logic [5:0] out_frame_index, out_next_frame_index;
  logic [7:0] out_blend_weight;

  cpu_load_level_meter dut (.*);

  always #5 clk = ~clk;

  // Predictor state: shadow registers and the sample ring.
  logic        m_excl;
  logic [7:0]  m_thr;
  logic        m_incr;
  logic [6:0]  m_frames;
  logic [SumW-1:0] ring_busy [Depth];
  logic [SumW-1:0] ring_total [Depth];
  int unsigned ring_slot;
  int          integ;
  int unsigned prev_level;

  meter_res_t expected_levels[$];
  int  errors = 0;
  bit  quiet = 0;       // no output stalls in the last part
  bit  rx_idle_en = 1;

  function automatic meter_res_t meter_predict(ticks_t t);
    logic [SumW-1:0] busy, total, ob, ot, db, dt;
    logic [SumW+8:0] prod;
    int unsigned load, lvl, fr, last, rng, idx;
    meter_res_t r;
    busy = SumW'(t.user) + SumW'(t.sys) + (m_excl ? '0 : SumW'(t.nice));
    total = SumW'(t.user) + SumW'(t.nice) + SumW'(t.sys) + SumW'(t.idle);
    ob = ring_busy[ring_slot];
    ot = ring_total[ring_slot];
    ring_busy[ring_slot] = busy;
    ring_total[ring_slot] = total;
    ring_slot = (ring_slot + 1) % Depth;
    if (ot == 0 || total == ot) load = 0;
    else begin
      db = (busy - ob) & Mask50;
      dt = (total - ot) & Mask50;
      if (db >= dt) load = 256;
      else begin
        prod = {db, 8'd0};
        load = int'(prod / dt);
      end
    end
    if (m_thr != 0) begin
      if (load < m_thr) load = 0;
      else load = ((load - m_thr) * 256) / (256 - m_thr);
    end
    integ = integ + int'(load / 50) - 3;
    if (integ < 0) integ = 0;
    if (integ > 256) integ = 256;
    lvl = m_incr ? integ : load;
    fr = m_frames;
    if (fr < 2) fr = 2;
    if (fr > 64) fr = 64;
    last = fr - 1;
    rng = 256 / last;
    idx = lvl / rng;
    if (idx > last) idx = last;
    r.level = LevelW'(lvl);
    r.changed = (lvl != prev_level);
    r.frame = 6'(idx);
    r.next_frame = (idx == last) ? 6'(idx) : 6'(idx + 1);
    r.weight = 8'(lvl % rng);
    r.range = LevelW'(rng);
    prev_level = lvl;
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegExcludeNice: m_excl = val[0];
      RegThreshold:   m_thr = val;
      RegIncremental: m_incr = val[0];
      RegFrameCount:  m_frames = val[6:0];
      default: ;
    endcase
  endtask

  // Drain: hold until every expected beat has arrived, then let the back settle.
  task automatic drain();
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Valid stays high between back-to-back beats; drop it only for a gap.
  task automatic send_beat(ticks_t t, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_user_ticks <= t.user;
    in_nice_ticks <= t.nice;
    in_system_ticks <= t.sys;
    in_idle_ticks <= t.idle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_levels.push_back(meter_predict(t));
  endtask

  // Output side: random stall bursts, then compare each beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected beat level=%0d", $time, out_level);
          errors++;
        end else begin
          meter_res_t e, a;
          e = expected_levels.pop_front();
          a = '{out_level, out_changed, out_frame_index, out_next_frame_index,
                out_blend_weight, out_blend_range};
          if (a !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, a);
            errors++;
          end
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet || !rx_idle_en) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  function automatic logic [TickW-1:0] rnd48();
    return {$urandom(), $urandom()};
  endfunction

  // Directed rows; only trivially known results are typed in.
  row_t dir_rows[$];

  initial begin
    ticks_t t, base;
    logic [TickW-1:0] mx;
    meter_res_t z;
    mx = '1;
    m_excl = 0; m_thr = 0; m_incr = 0; m_frames = 2;
    for (int i = 0; i < Depth; i++) begin
      ring_busy[i] = '0;
      ring_total[i] = '0;
    end
    ring_slot = 0; integ = 0; prev_level = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty slots after reset give level 0, range 256, frame 0 -> next 1.
    z = '{9'd0, 1'b0, 6'd0, 6'd1, 8'd0, 9'd256};
    dir_rows.push_back('{'{48'd0, 48'd0, 48'd0, 48'd0}, 1'b1, z});
    dir_rows.push_back('{'{mx, mx, mx, mx}, 1'b1, z});
    dir_rows.push_back('{'{48'd10, 48'd5, 48'd10, 48'd100}, 1'b1, z});
    for (int i = 3; i < Depth; i++)
      dir_rows.push_back('{'{48'(i*100), 48'(i*10), 48'(i*50), 48'(i*400)}, 1'b1, z});
    // Ring now full: equal totals, backwards counters, saturation, mixed.
    dir_rows.push_back('{'{48'd0, 48'd0, 48'd0, 48'd0}, 1'b0, z});
    dir_rows.push_back('{'{mx, 48'd0, 48'd0, 48'd0}, 1'b0, z});
    dir_rows.push_back('{'{48'd20, 48'd5, 48'd10, 48'd65}, 1'b0, z});
    dir_rows.push_back('{'{48'd400, 48'd30, 48'd150, 48'd1200}, 1'b0, z});
    dir_rows.push_back('{'{48'd500, 48'd40, 48'd250, 48'd1600}, 1'b0, z});
    dir_rows.push_back('{'{48'd9000, 48'd50, 48'd9000, 48'd2000}, 1'b0, z});
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].t, 1'b0);
      if (dir_rows[i].chk && dir_rows[i].res != expected_levels[$]) begin
        $display("%0t: table row %0d expected %p predicted %p", $time, i,
                 dir_rows[i].res, expected_levels[$]);
        errors++;
      end
    end
    in_valid <= 1'b0;
    drain();

    // Random phases with register sweeps; extremes first.
    base = '0;
    for (int ph = 0; ph < 13; ph++) begin
      case (ph)
        0: begin write_reg(RegExcludeNice, 1); write_reg(RegThreshold, 255);
                 write_reg(RegIncremental, 1); write_reg(RegFrameCount, 64); end
        1: begin write_reg(RegExcludeNice, 0); write_reg(RegThreshold, 0);
                 write_reg(RegIncremental, 0); write_reg(RegFrameCount, 2); end
        2: begin write_reg(RegFrameCount, 0); write_reg(RegThreshold, 1); end
        3: begin write_reg(RegFrameCount, 127); write_reg(RegIncremental, 1); end
        4: write_reg(RegFrameCount, 8'hFF);  // top bit dropped
        default: begin
          write_reg(RegExcludeNice, $urandom_range(0, 1));
          write_reg(RegThreshold, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255));
          write_reg(RegIncremental, $urandom_range(0, 1));
          write_reg(RegFrameCount, $urandom_range(0, 127));
        end
      endcase
      if (ph == 12) quiet = 1;
      rx_idle_en = (ph % 4 != 3);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          t = {rnd48(), rnd48(), rnd48(), rnd48()};  // noise / wrapping counters
        end else begin
          // Well-formed monotonic counters with random increments.
          base.user += $urandom_range(0, 1 << $urandom_range(0, 20));
          base.nice += $urandom_range(0, 1 << $urandom_range(0, 12));
          base.sys  += $urandom_range(0, 1 << $urandom_range(0, 18));
          base.idle += $urandom_range(0, 1 << $urandom_range(0, 20));
          t = base;
          if (k == 50) base = {mx - 48'd3000, mx - 48'd3000, mx - 48'd3000, mx - 48'd3000};
        end
        send_beat(t, !quiet);
      end
      in_valid <= 1'b0;
      if (ph == 6) drain();  // sender holds until every beat is back
      else while (expected_levels.size() != 0) @(posedge clk);
      if (ph != 12) repeat (150) @(posedge clk);
    end
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

// File: cpu_load_level_meter.f
hw/rtl/clm_pkg.sv
hw/rtl/clm_front.sv
hw/rtl/clm_queue.sv
hw/rtl/clm_back.sv
hw/rtl/cpu_load_level_meter.sv
test/tb_cpu_load_level_meter.sv
